/* hw/rtl/irpd_pkg.sv */
// shared types and constants of the pulse-distance frame encoder
`default_nettype none

package irpd_pkg;

    // widths of the payload fields
    localparam int unsigned DUR_W  = 15;
    localparam int unsigned BYTE_W = 8;

    // item position inside a run
    localparam int unsigned STEP_W = 5;

    // fixed space of the ending pair
    localparam logic [DUR_W-1:0] END_SPACE_TICKS = 15'h7FFF;

    // step of the terminator item for each frame kind, and of the header item
    localparam logic [STEP_W-1:0] STEP_DATA_TERM   = 5'd18;
    localparam logic [STEP_W-1:0] STEP_REPEAT_TERM = 5'd2;
    localparam logic [STEP_W-1:0] STEP_HEADER      = 5'd0;

    // request opcodes
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_REPEAT = 1'b1;

    // configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_LEAD_MARK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEAD_SPACE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MARK  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MARK   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_END_MARK   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INVERT     = 3'd7;

    // apb address and data widths
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // one request
    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } req_t;

    // one mark/space item
    typedef struct packed {
        logic             first_level;
        logic [DUR_W-1:0] first_duration;
        logic             second_level;
        logic [DUR_W-1:0] second_duration;
        logic             last;
    } item_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [DUR_W-1:0] lead_mark_ticks;
        logic [DUR_W-1:0] lead_space_ticks;
        logic [DUR_W-1:0] zero_mark_ticks;
        logic [DUR_W-1:0] zero_space_ticks;
        logic [DUR_W-1:0] one_mark_ticks;
        logic [DUR_W-1:0] one_space_ticks;
        logic [DUR_W-1:0] end_mark_ticks;
        logic             invert_levels;
    } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/ir_pulse_distance_frame_encoder.sv */
// top level of the pulse-distance infrared frame encoder
`default_nettype none

// A request (opcode, address, command) is taken on a rising edge with start
// high and busy low. It turns into a run of mark/space items, one per clock:
// a data frame gives 19 items (leading pair, 8 address bits and 8 command
// bits LSB first, ending pair, terminator), a repeat frame gives 3 (repeat
// pair, ending pair, terminator). Each item sits on result for exactly one
// cycle with result_valid high; the terminator carries last. The receiver
// cannot stall, so the run is never held off.
// The first item is built from the taken request and registered on result.
// The item step counter walks one item per cycle; busy drops in the cycle
// the terminator is built, so the next request is taken at the edge that
// registers the terminator into result, and runs follow with no gap.
// Configuration sits behind an APB port, register i at byte address 4*i;
// the user writes it only while idle (not enforced); pready is tied high.
// Reset zeroes the control and config registers and leaves the block idle.

module ir_pulse_distance_frame_encoder
    import irpd_pkg::*;
#(
    parameter int unsigned REPEAT_MARK_TICKS  = 9000,
    parameter int unsigned REPEAT_SPACE_TICKS = 2250
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire req_t              request,
    output logic                   result_valid,
    output item_t                  result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t                 cfg;
    req_t                 req_reg;
    req_t                 req_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 active_reg;
    logic                 active_next;
    item_t                result_reg;
    item_t                result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    logic [STEP_W-1:0]    term_step;
    logic                 is_term;
    logic                 is_end;
    logic [2*BYTE_W-1:0]  bits;
    logic [3:0]           bit_pos;
    logic                 bit_val;
    logic [DUR_W-1:0]     mark_dur;
    logic [DUR_W-1:0]     space_dur;
    logic                 take;

    // configuration registers
    irpd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // step decode
    assign term_step = (req_reg.opcode == OP_REPEAT) ? STEP_REPEAT_TERM : STEP_DATA_TERM;
    assign is_term   = (step_reg == term_step);
    assign is_end    = (step_reg == term_step - STEP_W'(1));
    assign bits      = {req_reg.command, req_reg.address};
    assign bit_pos   = step_reg[3:0] - 4'd1;
    assign bit_val   = bits[bit_pos];

    // handshake
    assign busy = active_reg && !is_term;
    assign take = start && !busy;

    // durations of the current item
    always_comb
    begin
        priority if (is_end)
        begin
            mark_dur  = cfg.end_mark_ticks;
            space_dur = END_SPACE_TICKS;
        end
        else if (step_reg == STEP_HEADER && req_reg.opcode == OP_REPEAT)
        begin
            mark_dur  = DUR_W'(REPEAT_MARK_TICKS);
            space_dur = DUR_W'(REPEAT_SPACE_TICKS);
        end
        else if (step_reg == STEP_HEADER)
        begin
            mark_dur  = cfg.lead_mark_ticks;
            space_dur = cfg.lead_space_ticks;
        end
        else if (bit_val)
        begin
            mark_dur  = cfg.one_mark_ticks;
            space_dur = cfg.one_space_ticks;
        end
        else
        begin
            mark_dur  = cfg.zero_mark_ticks;
            space_dur = cfg.zero_space_ticks;
        end
    end

    // item assembly, terminator is all zero with last set
    always_comb
    begin
        if (is_term)
        begin
            result_next      = '0;
            result_next.last = 1'b1;
        end
        else
        begin
            result_next.first_level     = !cfg.invert_levels;
            result_next.first_duration  = mark_dur;
            result_next.second_level    = cfg.invert_levels;
            result_next.second_duration = space_dur;
            result_next.last            = 1'b0;
        end
        result_valid_next = active_reg;
    end

    // sequencer next state
    always_comb
    begin
        req_next    = req_reg;
        step_next   = step_reg;
        active_next = active_reg;
        if (take)
        begin
            req_next    = request;
            step_next   = STEP_HEADER;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (is_term)
            begin
                active_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= '0;
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            active_reg       <= active_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* hw/rtl/irpd_regs.sv */
// apb configuration registers of the pulse-distance frame encoder
`default_nettype none

module irpd_regs
    import irpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [DUR_W-1:0]     wr_dur;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_dur = pwdata[DUR_W-1:0];
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LEAD_MARK:  cfg_next.lead_mark_ticks  = wr_dur;
                REG_LEAD_SPACE: cfg_next.lead_space_ticks = wr_dur;
                REG_ZERO_MARK:  cfg_next.zero_mark_ticks  = wr_dur;
                REG_ZERO_SPACE: cfg_next.zero_space_ticks = wr_dur;
                REG_ONE_MARK:   cfg_next.one_mark_ticks   = wr_dur;
                REG_ONE_SPACE:  cfg_next.one_space_ticks  = wr_dur;
                REG_END_MARK:   cfg_next.end_mark_ticks   = wr_dur;
                REG_INVERT:     cfg_next.invert_levels    = pwdata[0];
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_LEAD_MARK:  prdata = {(DATA_W-DUR_W)'(0), cfg_reg.lead_mark_ticks};
            REG_LEAD_SPACE: prdata = {(DATA_W-DUR_W)'(0), cfg_reg.lead_space_ticks};
            REG_ZERO_MARK:  prdata = {(DATA_W-DUR_W)'(0), cfg_reg.zero_mark_ticks};
            REG_ZERO_SPACE: prdata = {(DATA_W-DUR_W)'(0), cfg_reg.zero_space_ticks};
            REG_ONE_MARK:   prdata = {(DATA_W-DUR_W)'(0), cfg_reg.one_mark_ticks};
            REG_ONE_SPACE:  prdata = {(DATA_W-DUR_W)'(0), cfg_reg.one_space_ticks};
            REG_END_MARK:   prdata = {(DATA_W-DUR_W)'(0), cfg_reg.end_mark_ticks};
            REG_INVERT:     prdata = {(DATA_W-1)'(0), cfg_reg.invert_levels};
        endcase
    end

endmodule

`default_nettype wire

/* test/ir_pulse_distance_frame_encoder_tb.sv */
// self-checking testbench of the pulse-distance infrared frame encoder
`default_nettype none

module ir_pulse_distance_frame_encoder_tb
    import irpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DUR_W-1:0] REPEAT_MARK_TICKS  = 15'd9000;
    localparam logic [DUR_W-1:0] REPEAT_SPACE_TICKS = 15'd2250;
    localparam int unsigned      NUM_REGS           = 2 ** REG_IDX_W;
    localparam int unsigned      MAX_GAP            = 18;
    localparam int unsigned      RANDOM_BATCHES     = 8;
    localparam int unsigned      BATCH_ITEMS        = 20;
    localparam int unsigned      DIRECTED_ROWS      = 18;
    localparam int unsigned      REPORT_LIMIT       = 10;

    // directed stimulus row: register preset, request, optional typed first item
    typedef struct {
        int    preset;
        req_t  req;
        bit    has_head;
        item_t head;
    } frame_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    req_t                request = '0;
    logic                result_valid;
    item_t               result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // mirror of the configuration registers and items still to come
    cfg_t  shadow_cfg = '0;
    item_t pending_items[$];
    int    mismatches = 0;

    // register presets of the directed part: reset values, all extremes, typical timing
    cfg_t presets [3] = '{
        '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 1'b1},
        '{15'd9000, 15'd4500, 15'd560, 15'd560, 15'd560, 15'd1690, 15'd560, 1'b0}
    };

    frame_row_t directed_rows [DIRECTED_ROWS] = '{
        '{0, '{OP_REPEAT, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 15'd9000, 1'b0, 15'd2250, 1'b0}},
        '{0, '{OP_DATA, 8'h00, 8'h00}, 1'b1, '{1'b1, 15'd0, 1'b0, 15'd0, 1'b0}},
        '{0, '{OP_DATA, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 15'd0, 1'b0, 15'd0, 1'b0}},
        '{0, '{OP_DATA, 8'hA5, 8'h3C}, 1'b0, '0},
        '{1, '{OP_DATA, 8'hFF, 8'hFF}, 1'b1, '{1'b0, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0}},
        '{1, '{OP_DATA, 8'h00, 8'h00}, 1'b1, '{1'b0, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0}},
        '{1, '{OP_REPEAT, 8'h00, 8'h00}, 1'b1, '{1'b0, 15'd9000, 1'b1, 15'd2250, 1'b0}},
        '{1, '{OP_DATA, 8'h01, 8'h80}, 1'b0, '0},
        '{1, '{OP_DATA, 8'h80, 8'h01}, 1'b0, '0},
        '{1, '{OP_DATA, 8'h55, 8'hAA}, 1'b0, '0},
        '{2, '{OP_DATA, 8'h00, 8'hFF}, 1'b1, '{1'b1, 15'd9000, 1'b0, 15'd4500, 1'b0}},
        '{2, '{OP_DATA, 8'hFF, 8'h00}, 1'b0, '0},
        '{2, '{OP_REPEAT, 8'h00, 8'h00}, 1'b1, '{1'b1, 15'd9000, 1'b0, 15'd2250, 1'b0}},
        '{2, '{OP_REPEAT, 8'h5A, 8'hA5}, 1'b0, '0},
        '{2, '{OP_DATA, 8'h12, 8'hED}, 1'b0, '0},
        '{2, '{OP_DATA, 8'hAA, 8'h55}, 1'b0, '0},
        '{2, '{OP_DATA, 8'h7F, 8'hFE}, 1'b0, '0},
        '{2, '{OP_DATA, 8'hC3, 8'h96}, 1'b0, '0}
    };

    ir_pulse_distance_frame_encoder #(
        .REPEAT_MARK_TICKS  (REPEAT_MARK_TICKS),
        .REPEAT_SPACE_TICKS (REPEAT_SPACE_TICKS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // one mark/space pair at the current level polarity
    function automatic item_t mark_space_pair(input logic [DUR_W-1:0] mark,
                                              input logic [DUR_W-1:0] space);
        item_t pair;
        pair.first_level     = ~shadow_cfg.invert_levels;
        pair.first_duration  = mark;
        pair.second_level    = shadow_cfg.invert_levels;
        pair.second_duration = space;
        pair.last            = 1'b0;
        return pair;
    endfunction

    // full run of items that one request produces
    function automatic void encode_frame(input req_t req, ref item_t frame[$]);
        logic [2*BYTE_W-1:0] bits;
        item_t               term;
        frame = {};
        if (req.opcode == OP_REPEAT)
        begin
            frame.push_back(mark_space_pair(REPEAT_MARK_TICKS, REPEAT_SPACE_TICKS));
        end
        else
        begin
            frame.push_back(mark_space_pair(shadow_cfg.lead_mark_ticks,
                                            shadow_cfg.lead_space_ticks));
            // address then command, each lsb first
            bits = {req.command, req.address};
            for (int i = 0; i < 2 * BYTE_W; i++)
            begin
                if (bits[i])
                    frame.push_back(mark_space_pair(shadow_cfg.one_mark_ticks,
                                                    shadow_cfg.one_space_ticks));
                else
                    frame.push_back(mark_space_pair(shadow_cfg.zero_mark_ticks,
                                                    shadow_cfg.zero_space_ticks));
            end
        end
        frame.push_back(mark_space_pair(shadow_cfg.end_mark_ticks, END_SPACE_TICKS));
        // terminator ignores the level inversion
        term      = '0;
        term.last = 1'b1;
        frame.push_back(term);
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(input cfg_t c,
                                                    input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_LEAD_MARK:  return DATA_W'(c.lead_mark_ticks);
            REG_LEAD_SPACE: return DATA_W'(c.lead_space_ticks);
            REG_ZERO_MARK:  return DATA_W'(c.zero_mark_ticks);
            REG_ZERO_SPACE: return DATA_W'(c.zero_space_ticks);
            REG_ONE_MARK:   return DATA_W'(c.one_mark_ticks);
            REG_ONE_SPACE:  return DATA_W'(c.one_space_ticks);
            REG_END_MARK:   return DATA_W'(c.end_mark_ticks);
            default:        return DATA_W'(c.invert_levels);
        endcase
    endfunction

    // register update as the block sees it: value masked to the field width
    function automatic void store_reg(input logic [REG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        case (idx)
            REG_LEAD_MARK:  shadow_cfg.lead_mark_ticks  = data[DUR_W-1:0];
            REG_LEAD_SPACE: shadow_cfg.lead_space_ticks = data[DUR_W-1:0];
            REG_ZERO_MARK:  shadow_cfg.zero_mark_ticks  = data[DUR_W-1:0];
            REG_ZERO_SPACE: shadow_cfg.zero_space_ticks = data[DUR_W-1:0];
            REG_ONE_MARK:   shadow_cfg.one_mark_ticks   = data[DUR_W-1:0];
            REG_ONE_SPACE:  shadow_cfg.one_space_ticks  = data[DUR_W-1:0];
            REG_END_MARK:   shadow_cfg.end_mark_ticks   = data[DUR_W-1:0];
            default:        shadow_cfg.invert_levels    = data[0];
        endcase
    endfunction

    // duration with a bias toward both extremes
    function automatic logic [DUR_W-1:0] pick_ticks();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return DUR_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.lead_mark_ticks  = pick_ticks();
        c.lead_space_ticks = pick_ticks();
        c.zero_mark_ticks  = pick_ticks();
        c.zero_space_ticks = pick_ticks();
        c.one_mark_ticks   = pick_ticks();
        c.one_space_ticks  = pick_ticks();
        c.end_mark_ticks   = pick_ticks();
        c.invert_levels    = 1'($urandom);
        return c;
    endfunction

    // apb transfer, entered and left at a falling edge; reads are checked
    task automatic apb_transfer(input logic write, input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] want;
        want    = reg_value(shadow_cfg, idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!write && prdata !== want)
        begin
            note_mismatch($sformatf("register %0d read 0x%08h, want 0x%08h",
                                    idx, prdata, want));
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        @(negedge clk);
    endtask

    // write every register, with junk above each field, then read all back
    task automatic load_settings(input cfg_t s);
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
        int                   w;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx  = REG_IDX_W'(i);
            w    = (idx == REG_INVERT) ? 1 : DUR_W;
            data = ($urandom << w) | reg_value(s, idx);
            apb_transfer(1'b1, idx, data);
            store_reg(idx, data);
        end
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_transfer(1'b0, REG_IDX_W'(i), '0);
        end
    endtask

    // stop requesting and let every outstanding item arrive
    task automatic wait_for_drain();
        start = 1'b0;
        while (pending_items.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // hand one request over; entered and left at a falling edge
    task automatic send_request(input req_t req, input int gap, input bit has_head,
                                input item_t head);
        item_t frame[$];
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = req;
        start   = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        encode_frame(req, frame);
        if (has_head)
            frame[0] = head;
        foreach (frame[i])
            pending_items.push_back(frame[i]);
        @(negedge clk);
    endtask

    // result checker: every strobed item against the oldest outstanding one
    always @(posedge clk)
    begin
        item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_items.size() == 0)
            begin
                note_mismatch($sformatf("unexpected item %p", result));
            end
            else
            begin
                want = pending_items.pop_front();
                if (result.first_level !== want.first_level)
                    note_mismatch($sformatf("first_level %0b, want %0b",
                                            result.first_level, want.first_level));
                if (result.first_duration !== want.first_duration)
                    note_mismatch($sformatf("first_duration %0d, want %0d",
                                            result.first_duration, want.first_duration));
                if (result.second_level !== want.second_level)
                    note_mismatch($sformatf("second_level %0b, want %0b",
                                            result.second_level, want.second_level));
                if (result.second_duration !== want.second_duration)
                    note_mismatch($sformatf("second_duration %0d, want %0d",
                                            result.second_duration, want.second_duration));
                if (result.last !== want.last)
                    note_mismatch($sformatf("last %0b, want %0b",
                                            result.last, want.last));
            end
        end
    end

    // stimulus
    initial
    begin
        int   cur_preset;
        int   gap;
        bit   no_gaps;
        req_t req;
        cur_preset = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, back to back, register preset switched while idle
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].preset != cur_preset)
            begin
                wait_for_drain();
                cur_preset = directed_rows[i].preset;
                load_settings(presets[cur_preset]);
            end
            send_request(directed_rows[i].req, 0, directed_rows[i].has_head,
                         directed_rows[i].head);
        end

        // random batches, each under fresh register values
        for (int b = 0; b < RANDOM_BATCHES; b++)
        begin
            wait_for_drain();
            load_settings(random_settings());
            no_gaps = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < BATCH_ITEMS; n++)
            begin
                req.opcode  = ($urandom_range(0, 3) == 0) ? OP_REPEAT : OP_DATA;
                req.address = BYTE_W'($urandom);
                req.command = BYTE_W'($urandom);
                gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
                send_request(req, gap, 1'b0, '0);
            end
        end

        wait_for_drain();
        repeat (25) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
